>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define BAA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define BAA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/baa_pkg.sv
package baa_pkg;

  // Operand and result formats
  localparam int COORD_WIDTH     = 32;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int OUT_W           = ANGLE_FRAC_BITS + 2;

  // Front end widths
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int DOT_W   = PROD_W + 2;
  localparam int MAG_W   = 2 * COORD_WIDTH + 2;
  localparam int HALF_W  = MAG_W / 2;
  localparam int SQ_W    = 2 * MAG_W;

  // Square root
  localparam int ROOT_W = MAG_W;
  localparam int REM_W  = ROOT_W + 2;

  // Normalization and CORDIC
  localparam int NORM_BITS = 52;
  localparam int LZ_W      = $clog2(MAG_W + 1);
  localparam int XY_W      = NORM_BITS + 6;
  localparam int ACC_FRAC  = 44;
  localparam int ITERS     = 44;
  localparam int ACC_W     = ACC_FRAC + 4;
  localparam int SER_FRAC  = 60;
  localparam int TAB_DROP  = SER_FRAC - ACC_FRAC;
  localparam int DROP      = ACC_FRAC - ANGLE_FRAC_BITS;

  localparam logic [63:0] SER_ONE = 64'd1 << SER_FRAC;

  // Dot product side info carried along the root pipeline
  typedef struct packed {
    logic [MAG_W-1:0] dot_mag;
    logic             dot_neg;
  } side_t;

  // Normalized operands handed to the CORDIC
  typedef struct packed {
    logic [NORM_BITS-1:0] xm;
    logic [NORM_BITS-1:0] ym;
    logic                 dot_neg;
    logic                 zero;
  } norm_t;

  // Shift-subtract division, used only to build constants
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) scaled by 2^60, truncated series
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] sum;
    logic [63:0] pw;
    logic [63:0] k;
    logic [63:0] t;
    logic [63:0] lim;
    logic        done;
    sum  = '0;
    pw   = n;
    k    = '0;
    done = 1'b0;
    lim  = udiv(udiv(SER_ONE, n), n);
    for (int it = 0; it < 64; it++) begin
      if (!done) begin
        t = udiv(udiv(SER_ONE, pw), 64'd2 * k + 64'd1);
        if (!k[0]) sum = sum + t;
        else sum = sum - t;
        if (pw > lim) begin
          done = 1'b1;
        end else begin
          pw = pw * n * n;
          k  = k + 64'd1;
        end
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] quarter_pi();
    return atan_recip(64'd2) + atan_recip(64'd3);
  endfunction

  // Micro-rotation angle of step i, 44 fraction bits
  function automatic logic [ACC_W-1:0] rot_val(input int i);
    logic [63:0] v;
    if (i == 0) v = quarter_pi();
    else v = atan_recip(64'd1 << i);
    v = (v + (64'd1 << (TAB_DROP - 1))) >> TAB_DROP;
    return v[ACC_W-1:0];
  endfunction

  function automatic logic [63:0] pi_acc64();
    return (64'd4 * quarter_pi() + (64'd1 << (TAB_DROP - 1))) >> TAB_DROP;
  endfunction

  localparam logic [63:0]      PI_ACC64 = pi_acc64();
  localparam logic [ACC_W-1:0] PI_ACC   = PI_ACC64[ACC_W-1:0];
  localparam logic [63:0]      PI_RND   = (PI_ACC64 + (64'd1 << (DROP - 1))) >> DROP;
  localparam logic [OUT_W-1:0] PI_OUT   = PI_RND[OUT_W-1:0];

endpackage

>>> rtl/baa_vec.sv
module baa_vec import baa_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] a_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_z_i,
  input  logic signed [COORD_WIDTH-1:0] b_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_z_i,
  input  logic signed [COORD_WIDTH-1:0] c_x_i,
  input  logic signed [COORD_WIDTH-1:0] c_y_i,
  input  logic signed [COORD_WIDTH-1:0] c_z_i,
  output logic                          valid_o,
  output logic [SQ_W-1:0]               sq_o,
  output side_t                         side_o
);

  localparam int NSTG = 7;

  logic signed [COORD_WIDTH-1:0] pa [3];
  logic signed [COORD_WIDTH-1:0] pb [3];
  logic signed [COORD_WIDTH-1:0] pc [3];

  assign pa[0] = a_x_i;
  assign pa[1] = a_y_i;
  assign pa[2] = a_z_i;
  assign pb[0] = b_x_i;
  assign pb[1] = b_y_i;
  assign pb[2] = b_z_i;
  assign pc[0] = c_x_i;
  assign pc[1] = c_y_i;
  assign pc[2] = c_z_i;

  logic                     vld_q [NSTG];
  logic signed [DIFF_W-1:0]  du_q [3];
  logic signed [DIFF_W-1:0]  dv_q [3];
  logic signed [PROD_W-1:0]  pra_q [3];
  logic signed [PROD_W-1:0]  prb_q [3];
  logic signed [PROD_W-1:0]  prd_q [3];
  logic signed [CROSS_W-1:0] cross_q [3];
  logic signed [DOT_W-1:0]   dot_q;
  logic [MAG_W-1:0]          cmag_q [3];
  logic [2*HALF_W-1:0]       hh_q [3];
  logic [2*HALF_W-1:0]       hl_q [3];
  logic [2*HALF_W-1:0]       ll_q [3];
  logic [SQ_W-1:0]           sqr_q [3];
  logic [SQ_W-1:0]           sum_q;
  side_t                     side4_q;
  side_t                     side5_q;
  side_t                     side6_q;
  side_t                     side7_q;

  logic signed [DOT_W-1:0]   dot_abs;

  // valid bits move with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTG; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < NSTG; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  assign dot_abs = dot_q[DOT_W-1] ? -dot_q : dot_q;

  // bond vectors, products, cross and dot terms, magnitudes, squares
  for (genvar gi = 0; gi < 3; gi++) begin : g_axis
    localparam int J = (gi + 1) % 3;
    localparam int K = (gi + 2) % 3;
    logic signed [CROSS_W-1:0] cabs;
    logic [HALF_W-1:0]         mh;
    logic [HALF_W-1:0]         ml;

    assign cabs = cross_q[gi][CROSS_W-1] ? -cross_q[gi] : cross_q[gi];
    assign mh   = cmag_q[gi][MAG_W-1:HALF_W];
    assign ml   = cmag_q[gi][HALF_W-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        du_q[gi]    <= DIFF_W'(pb[gi]) - DIFF_W'(pa[gi]);
        dv_q[gi]    <= DIFF_W'(pc[gi]) - DIFF_W'(pb[gi]);
        pra_q[gi]   <= PROD_W'(du_q[J]) * PROD_W'(dv_q[K]);
        prb_q[gi]   <= PROD_W'(du_q[K]) * PROD_W'(dv_q[J]);
        prd_q[gi]   <= PROD_W'(du_q[gi]) * PROD_W'(dv_q[gi]);
        cross_q[gi] <= CROSS_W'(pra_q[gi]) - CROSS_W'(prb_q[gi]);
        cmag_q[gi]  <= cabs[MAG_W-1:0];
        hh_q[gi]    <= (2*HALF_W)'(mh) * (2*HALF_W)'(mh);
        hl_q[gi]    <= (2*HALF_W)'(mh) * (2*HALF_W)'(ml);
        ll_q[gi]    <= (2*HALF_W)'(ml) * (2*HALF_W)'(ml);
        sqr_q[gi]   <= (SQ_W'(hh_q[gi]) << (2*HALF_W)) + (SQ_W'(hl_q[gi]) << (HALF_W + 1))
                       + SQ_W'(ll_q[gi]);
      end
    end
  end

  // dot sum, sum of squares, side info
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q           <= DOT_W'(prd_q[0]) + DOT_W'(prd_q[1]) + DOT_W'(prd_q[2]);
      side4_q.dot_mag <= dot_abs[MAG_W-1:0];
      side4_q.dot_neg <= dot_q[DOT_W-1];
      side5_q         <= side4_q;
      side6_q         <= side5_q;
      side7_q         <= side6_q;
      sum_q           <= sqr_q[0] + sqr_q[1] + sqr_q[2];
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign sq_o    = sum_q;
  assign side_o  = side7_q;

endmodule

>>> rtl/baa_isqrt.sv
module baa_isqrt import baa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   sq_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  // one root bit per stage, restoring form
  logic              vld_q  [ROOT_W];
  logic [SQ_W-1:0]   rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  side_t             side_q [ROOT_W];

  for (genvar gk = 0; gk < ROOT_W; gk++) begin : g_stage
    logic              vld_in;
    logic [SQ_W-1:0]   rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    side_t             side_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              geq;

    if (gk == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rad_in  = sq_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[gk-1];
      assign rad_in  = rad_q[gk-1];
      assign rem_in  = rem_q[gk-1];
      assign root_in = root_q[gk-1];
      assign side_in = side_q[gk-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign geq    = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[gk] <= 1'b0;
      end else if (en_i) begin
        vld_q[gk] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[gk]  <= rad_in << 2;
        rem_q[gk]  <= geq ? rem_sh - trial : rem_sh;
        root_q[gk] <= {root_in[ROOT_W-2:0], geq};
        side_q[gk] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

>>> rtl/baa_norm.sv
module baa_norm import baa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [ROOT_W-1:0] root_i,
  input  side_t             side_i,
  output logic              valid_o,
  output norm_t             norm_o
);

  localparam int EXT_W = MAG_W + NORM_BITS;

  logic [MAG_W-1:0] orv;
  logic [LZ_W-1:0]  lz;

  logic             vld1_q;
  logic             vld2_q;
  logic [LZ_W-1:0]  lz_q;
  logic [MAG_W-1:0] dot_q;
  logic [MAG_W-1:0] root_q;
  logic             neg_q;
  logic             zero_q;
  norm_t            norm_q;

  logic [EXT_W-1:0] xs;
  logic [EXT_W-1:0] ys;

  // leading zeros of the larger operand
  assign orv = side_i.dot_mag | root_i;

  always_comb begin
    lz = LZ_W'(MAG_W);
    for (int b = 0; b < MAG_W; b++) begin
      if (orv[b]) lz = LZ_W'(MAG_W - 1 - b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  // align so the top set bit lands in the operand MSB
  assign xs = {dot_q, NORM_BITS'(0)} << lz_q;
  assign ys = {root_q, NORM_BITS'(0)} << lz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lz_q           <= lz;
      dot_q          <= side_i.dot_mag;
      root_q         <= root_i;
      neg_q          <= side_i.dot_neg;
      zero_q         <= (root_i == '0);
      norm_q.xm      <= xs[EXT_W-1 -: NORM_BITS];
      norm_q.ym      <= ys[EXT_W-1 -: NORM_BITS];
      norm_q.dot_neg <= neg_q;
      norm_q.zero    <= zero_q;
    end
  end

  assign valid_o = vld2_q;
  assign norm_o  = norm_q;

endmodule

>>> rtl/baa_cordic.sv
`include "assert_macros.svh"

module baa_cordic import baa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  norm_t            norm_i,
  output logic             valid_o,
  output logic [OUT_W-1:0] angle_o
);

  localparam logic [ACC_W-1:0] ROT0     = rot_val(0);
  localparam logic [ACC_W-1:0] HALF_RND = ACC_W'(1) << (DROP - 1);

  logic                    pre_vld_q;
  logic signed [XY_W-1:0]  pre_x_q;
  logic signed [XY_W-1:0]  pre_y_q;
  logic signed [ACC_W-1:0] pre_acc_q;
  logic                    pre_neg_q;
  logic                    pre_zero_q;

  logic                    vld_q  [ITERS];
  logic signed [XY_W-1:0]  x_q    [ITERS];
  logic signed [XY_W-1:0]  y_q    [ITERS];
  logic signed [ACC_W-1:0] acc_q  [ITERS];
  logic                    neg_q  [ITERS];
  logic                    zero_q [ITERS];

  logic                    res_vld_q;
  logic [OUT_W-1:0]        res_q;

  logic signed [ACC_W-1:0] acc_end;
  logic [ACC_W-1:0]        acc_cl;
  logic [ACC_W-1:0]        acc_rnd;
  logic [OUT_W-1:0]        res_d;

  // fold into the first quadrant: obtuse angles start from pi/2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else if (en_i) begin
      pre_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_x_q    <= XY_W'(norm_i.dot_neg ? norm_i.ym : norm_i.xm);
      pre_y_q    <= XY_W'(norm_i.dot_neg ? norm_i.xm : norm_i.ym);
      pre_acc_q  <= norm_i.dot_neg ? $signed(ROT0 << 1) : '0;
      pre_neg_q  <= norm_i.dot_neg;
      pre_zero_q <= norm_i.zero;
    end
  end

  // vectoring micro-rotations, one per stage
  for (genvar gi = 0; gi < ITERS; gi++) begin : g_iter
    localparam logic [ACC_W-1:0] ROT = rot_val(gi);
    logic                    vld_in;
    logic signed [XY_W-1:0]  x_in;
    logic signed [XY_W-1:0]  y_in;
    logic signed [ACC_W-1:0] acc_in;
    logic                    neg_in;
    logic                    zero_in;

    if (gi == 0) begin : g_first
      assign vld_in  = pre_vld_q;
      assign x_in    = pre_x_q;
      assign y_in    = pre_y_q;
      assign acc_in  = pre_acc_q;
      assign neg_in  = pre_neg_q;
      assign zero_in = pre_zero_q;
    end else begin : g_next
      assign vld_in  = vld_q[gi-1];
      assign x_in    = x_q[gi-1];
      assign y_in    = y_q[gi-1];
      assign acc_in  = acc_q[gi-1];
      assign neg_in  = neg_q[gi-1];
      assign zero_in = zero_q[gi-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[gi] <= 1'b0;
      end else if (en_i) begin
        vld_q[gi] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[XY_W-1]) begin
          x_q[gi]   <= x_in + (y_in >>> gi);
          y_q[gi]   <= y_in - (x_in >>> gi);
          acc_q[gi] <= acc_in + $signed(ROT);
        end else begin
          x_q[gi]   <= x_in - (y_in >>> gi);
          y_q[gi]   <= y_in + (x_in >>> gi);
          acc_q[gi] <= acc_in - $signed(ROT);
        end
        neg_q[gi]  <= neg_in;
        zero_q[gi] <= zero_in;
      end
    end
  end

  // clamp to [0, pi], round half up; a zero root gives 0 or pi
  assign acc_end = acc_q[ITERS-1];

  always_comb begin
    if (acc_end[ACC_W-1]) acc_cl = '0;
    else if (acc_end > $signed(PI_ACC)) acc_cl = PI_ACC;
    else acc_cl = acc_end;
    acc_rnd = acc_cl + HALF_RND;
    if (zero_q[ITERS-1]) res_d = neg_q[ITERS-1] ? PI_OUT : '0;
    else res_d = acc_rnd[DROP +: OUT_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (en_i) begin
      res_vld_q <= vld_q[ITERS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign valid_o = res_vld_q;
  assign angle_o = res_q;

  `BAA_ASSERT(a_angle_range, res_vld_q |-> (res_q <= PI_OUT), "angle above pi")

endmodule

>>> rtl/bond_angle_atan2_unit.sv
// Bond bend angle unit.
// Input channel: in_valid_i / in_stall_o carry one word of three points A, B, C
// (signed Q16.16 per coordinate). A word is taken on a clock edge with
// in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry bend_angle_o, the angle
// between B-A and C-B in radians, unsigned Q2.16, 0 to pi. Parallel or zero
// bond vectors give 0, or pi when the dot product is negative.
// Pipeline: 7 front end stages (differences, products, cross and dot,
// magnitudes, squares, sum), 66 square root stages (one root bit each),
// 2 normalize stages, 46 CORDIC stages (fold, 44 rotations, round) and the
// output register. Throughput: one word per cycle while in_stall_o is low,
// set by the fully pipelined datapath.
// When the receiver stalls, the next finished word parks in a one-entry skid
// register; the pipeline freezes and in_stall_o rises the cycle after, so no
// word is lost or repeated. Words in flight keep their order.
// Reset clears all valid bits; no other register is reset.
`include "assert_macros.svh"

module bond_angle_atan2_unit import baa_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] point_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] point_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] point_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_c_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [OUT_W-1:0]              bend_angle_o
);

  logic              en;
  logic              vec_vld;
  logic [SQ_W-1:0]   vec_sq;
  side_t             vec_side;
  logic              rt_vld;
  logic [ROOT_W-1:0] rt_root;
  side_t             rt_side;
  logic              nm_vld;
  norm_t             nm_word;
  logic              cd_vld;
  logic [OUT_W-1:0]  cd_angle;

  logic              out_vq;
  logic [OUT_W-1:0]  out_dq;
  logic              skid_vq;
  logic [OUT_W-1:0]  skid_dq;
  logic              take;

  // whole pipeline advances while the skid slot is free
  assign en         = !skid_vq;
  assign in_stall_o = skid_vq;

  baa_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .a_x_i   (point_a_x_i),
    .a_y_i   (point_a_y_i),
    .a_z_i   (point_a_z_i),
    .b_x_i   (point_b_x_i),
    .b_y_i   (point_b_y_i),
    .b_z_i   (point_b_z_i),
    .c_x_i   (point_c_x_i),
    .c_y_i   (point_c_y_i),
    .c_z_i   (point_c_z_i),
    .valid_o (vec_vld),
    .sq_o    (vec_sq),
    .side_o  (vec_side)
  );

  baa_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vec_vld),
    .sq_i    (vec_sq),
    .side_i  (vec_side),
    .valid_o (rt_vld),
    .root_o  (rt_root),
    .side_o  (rt_side)
  );

  baa_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_vld),
    .root_i  (rt_root),
    .side_i  (rt_side),
    .valid_o (nm_vld),
    .norm_o  (nm_word)
  );

  baa_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_vld),
    .norm_i  (nm_word),
    .valid_o (cd_vld),
    .angle_o (cd_angle)
  );

  // output register with one-entry skid
  assign take = out_vq && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (skid_vq) begin
      if (take) begin
        out_vq  <= 1'b1;
        skid_vq <= 1'b0;
      end
    end else if (!out_vq || take) begin
      out_vq <= cd_vld;
    end else if (cd_vld) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vq) begin
      if (take) out_dq <= skid_dq;
    end else if (!out_vq || take) begin
      out_dq <= cd_angle;
    end else begin
      skid_dq <= cd_angle;
    end
  end

  assign out_valid_o  = out_vq;
  assign bend_angle_o = out_dq;

  `BAA_ASSERT_ALWAYS(a_skid_behind_out, skid_vq |-> out_vq, "skid word without output word")
  `BAA_ASSERT(a_skid_on_stall, $rose(skid_vq) |-> $past(out_vq && out_stall_i), "skid filled without stall")
  `BAA_ASSERT(a_skid_drains, (skid_vq && !out_stall_i) |=> !skid_vq, "skid not drained")

endmodule

>>> tb/bond_angle_atan2_unit_tb.sv
module bond_angle_atan2_unit_tb import baa_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1250;
  localparam int IDLE_LIMIT = 3000;
  localparam int MAX_SHOWN  = 10;
  localparam int TAIL_WAIT  = 140;
  localparam int WIDE       = 140;
  localparam longint unsigned SERIES_ONE = 64'd1 << 60;
  localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] ONE   = 32'sd65536;

  // Word layout: [0..2] point A xyz, [3..5] point B, [6..8] point C
  typedef logic [8:0][COORD_WIDTH-1:0] word_t;
  typedef logic signed [WIDE-1:0] wide_t;

  typedef struct {
    word_t            w;
    bit               known;
    logic [OUT_W-1:0] angle;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  word_t in_word = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [OUT_W-1:0] bend_angle_o;

  logic [OUT_W-1:0] angles_due[$];
  longint rot_angle[ITERS];
  longint pi_fixed;
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stall_quiet = 1'b0;

  always #4 clk_i = ~clk_i;

  bond_angle_atan2_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .point_a_x_i (in_word[0]),
    .point_a_y_i (in_word[1]),
    .point_a_z_i (in_word[2]),
    .point_b_x_i (in_word[3]),
    .point_b_y_i (in_word[4]),
    .point_b_z_i (in_word[5]),
    .point_c_x_i (in_word[6]),
    .point_c_y_i (in_word[7]),
    .point_c_z_i (in_word[8]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bend_angle_o(bend_angle_o)
  );

  // atan(1/n) scaled by 2^60 from the alternating series
  function automatic longint unsigned arctan_inv(longint unsigned n);
    longint unsigned sum, pw, k, t;
    sum = 0;
    pw  = n;
    k   = 0;
    while (1) begin
      t = (SERIES_ONE / pw) / (2 * k + 1);
      if (!k[0]) sum += t;
      else sum -= t;
      if (pw > SERIES_ONE / n / n) break;
      pw = pw * n * n;
      k++;
    end
    return sum;
  endfunction

  function automatic void build_rotations();
    longint unsigned quarter;
    quarter      = arctan_inv(2) + arctan_inv(3);
    rot_angle[0] = longint'((quarter + (64'd1 << 15)) >> 16);
    for (int i = 1; i < ITERS; i++)
      rot_angle[i] = longint'((arctan_inv(64'd1 << i) + (64'd1 << 15)) >> 16);
    pi_fixed = longint'((4 * quarter + (64'd1 << 15)) >> 16);
  endfunction

  function automatic int bit_length(wide_t v);
    for (int i = WIDE - 1; i >= 0; i--)
      if (v[i]) return i + 1;
    return 0;
  endfunction

  // Angle between B-A and C-B: exact cross/dot, integer root, CORDIC atan2
  function automatic logic [OUT_W-1:0] bend_angle_of(word_t w);
    wide_t u[3], v[3], cr[3], dot, dmag, sq, root, trial, xw, yw;
    longint x, y, acc, xs, ys;
    int len, sh;
    for (int i = 0; i < 3; i++) begin
      u[i] = wide_t'($signed(w[3+i])) - wide_t'($signed(w[i]));
      v[i] = wide_t'($signed(w[6+i])) - wide_t'($signed(w[3+i]));
    end
    for (int i = 0; i < 3; i++)
      cr[i] = u[(i+1)%3] * v[(i+2)%3] - u[(i+2)%3] * v[(i+1)%3];
    dot  = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    dmag = dot < 0 ? -dot : dot;
    sq   = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
    root = '0;
    for (int i = 69; i >= 0; i--) begin
      trial = root | (wide_t'(1) << i);
      if ($unsigned(trial * trial) <= $unsigned(sq)) root = trial;
    end
    // parallel or zero bond vectors
    if (root == 0)
      return dot < 0 ? OUT_W'((pi_fixed + (64'sd1 << (DROP - 1))) >> DROP) : '0;
    len = bit_length(root);
    if (bit_length(dmag) > len) len = bit_length(dmag);
    sh = len - NORM_BITS;
    if (sh >= 0) begin
      xw = dmag >> sh;
      yw = root >> sh;
    end else begin
      xw = dmag << (-sh);
      yw = root << (-sh);
    end
    // fold a negative dot product into the first quadrant
    if (dot < 0) begin
      x = longint'(yw[63:0]); y = longint'(xw[63:0]); acc = 2 * rot_angle[0];
    end else begin
      x = longint'(xw[63:0]); y = longint'(yw[63:0]); acc = 0;
    end
    for (int i = 0; i < ITERS; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (y >= 0) begin
        x += xs; y -= ys; acc += rot_angle[i];
      end else begin
        x -= xs; y += ys; acc -= rot_angle[i];
      end
    end
    if (acc < 0) acc = 0;
    if (acc > pi_fixed) acc = pi_fixed;
    return OUT_W'((acc + (64'sd1 << (DROP - 1))) >> DROP);
  endfunction

  function automatic word_t points(
      logic [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    word_t w;
    w = '0;
    w[0] = ax; w[1] = ay; w[2] = az;
    w[3] = bx; w[4] = by; w[5] = bz;
    w[6] = cx; w[7] = cy; w[8] = cz;
    return w;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    return $urandom;
  endfunction

  // Random word: wild coordinates, a short chain, or collinear bonds
  function automatic word_t random_word();
    word_t w;
    logic signed [COORD_WIDTH-1:0] d[3];
    int span, k;
    span = 1 << $urandom_range(0, 22);
    case ($urandom_range(0, 3))
      0: for (int i = 0; i < 9; i++) w[i] = rand_coord();
      1: begin
        for (int i = 0; i < 3; i++) begin
          w[i]   = rand_coord();
          w[3+i] = w[i] + $urandom_range(0, 2 * span) - span;
          w[6+i] = w[3+i] + $urandom_range(0, 2 * span) - span;
        end
      end
      default: begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < 3; i++) begin
          d[i]   = $urandom_range(0, 2 * span) - span;
          w[i]   = rand_coord();
          w[3+i] = w[i] + d[i];
          w[6+i] = $urandom_range(0, 1) ? w[3+i] + k * d[i] : w[3+i] - k * d[i];
        end
        // nudge one coordinate now and then for near-parallel bonds
        if ($urandom_range(0, 1)) w[6 + $urandom_range(0, 2)] += $urandom_range(1, 3);
      end
    endcase
    return w;
  endfunction

  // Send one word after a gap; valid stays high across back-to-back words
  task automatic send_word(word_t w, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word    <= w;
    do @(posedge clk_i); while (in_stall_o);
    angles_due.push_back(bend_angle_of(w));
  endtask

  // Receiver stall: a random hold after each taken word, none while stall_quiet is set
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) stall_left = stall_quiet ? 0 : $urandom_range(0, 9);
    else if (stall_left > 0) stall_left--;
    out_stall_i <= (stall_left != 0);
  end

  // Result check against the oldest expected angle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (angles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result word: bend_angle %0d", bend_angle_o);
      end else begin
        if (bend_angle_o !== angles_due[0]) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("bend_angle mismatch: expected %0d got %0d", angles_due[0], bend_angle_o);
        end
        void'(angles_due.pop_front());
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("bond_angle_atan2_unit_tb failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int gap;
    bit quiet_send;
    build_rotations();

    // directed rows
    rows.push_back('{points(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0});
    rows.push_back('{points(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX),
                     1, '0});
    rows.push_back('{points(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN),
                     1, PI_OUT});
    rows.push_back('{points(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX),
                     1, PI_OUT});
    rows.push_back('{points(C_MIN, C_MIN, C_MIN, 0, 0, 0, C_MAX, C_MAX, C_MAX), 0, '0});
    rows.push_back('{points(C_MIN, 0, 0, C_MAX, 0, 0, C_MAX, C_MAX, 0), 0, '0});
    rows.push_back('{points(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX),
                     0, '0});
    rows.push_back('{points(0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0), 1, '0});
    rows.push_back('{points(0, 0, 0, ONE, 0, 0, 0, 0, 0), 1, PI_OUT});
    rows.push_back('{points(5, 6, 7, 5, 6, 7, ONE, -ONE, 3), 1, '0});
    rows.push_back('{points(ONE, 2, 3, 4, 5, 6, 4, 5, 6), 1, '0});
    rows.push_back('{points(0, 0, 0, ONE, 0, 0, ONE, ONE, 0), 0, '0});
    rows.push_back('{points(0, 0, 0, 0, 0, ONE, ONE, 0, ONE), 0, '0});
    rows.push_back('{points(0, 0, 0, 1, 0, 0, 1, 1, 0), 0, '0});
    rows.push_back('{points(0, 0, 0, ONE, 0, 0, ONE + ONE / 2, ONE, 0), 0, '0});
    rows.push_back('{points(0, 0, 0, ONE, 0, 0, ONE / 2, ONE, 0), 0, '0});
    rows.push_back('{points(0, 0, 0, ONE, ONE, 0, 0, 2 * ONE, 1), 0, '0});
    rows.push_back('{points(0, 0, 0, 1, 0, 0, 0, 1, 0), 0, '0});
    rows.push_back('{points(-1, -1, -1, 0, 0, 0, 1, 1, 1), 1, '0});
    rows.push_back('{points(C_MAX, 0, 0, C_MIN, 0, 0, C_MIN, C_MAX, 0), 0, '0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      if (rows[r].known && bend_angle_of(rows[r].w) !== rows[r].angle) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("directed row %0d: table angle %0d, predicted %0d",
                   r, rows[r].angle, bend_angle_of(rows[r].w));
      end
      send_word(rows[r].w, $urandom_range(0, 3));
    end

    quiet_send = 1'b0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // every 150 words, choose between random gaps and full rate, and whether the receiver stalls
      if (n % 150 == 0) begin
        quiet_send  = $urandom_range(0, 2) == 0;
        stall_quiet = $urandom_range(0, 2) == 0;
      end
      if (n == NUM_RANDOM / 2) begin
        in_valid_i <= 1'b0;
        wait (angles_due.size() == 0);
        @(posedge clk_i);
      end
      gap = quiet_send ? 0 : $urandom_range(0, 9);
      send_word(random_word(), gap);
    end
    in_valid_i <= 1'b0;

    wait (angles_due.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && angles_due.size() == 0)
      $display("bond_angle_atan2_unit_tb passed");
    else
      $display("bond_angle_atan2_unit_tb failed");
    $finish;
  end

endmodule
